// ----- rtl/core/huffman_code_bit_packer_assert.svh -----
// ----------------------------------------------------------------------------
// Huffman code bit packer assertion macros
// Clocked assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_ASSERT_SVH

`ifndef SYNTHESIS
`define HCBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HCBP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HCBP_ASSERT(lbl, prop, msg)
`define HCBP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/hcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbp_pkg
// Types and constants shared by the Huffman code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int CODE_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int SYM_W       = 8;
  localparam int OP_W        = 2;
  localparam int IN_LEN_W    = 6;
  localparam int TABLE_DEPTH = 256;
  localparam int ACC_W       = CODE_W + BYTE_W;
  localparam int CNT_W       = 6;
  localparam int SH_W        = 7;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]     opcode;
    logic [SYM_W-1:0]    symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [IN_LEN_W-1:0] code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] opcode;
  } issue_t;

endpackage

// ----- rtl/core/hcbp_code_table.sv -----
// ----------------------------------------------------------------------------
// hcbp_code_table
// 256-entry code word / length memory, one write and one registered read.
// ----------------------------------------------------------------------------
module hcbp_code_table #(
  parameter int LEN_W = 6
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [hcbp_pkg::SYM_W-1:0]        wr_addr,
  input  logic [LEN_W+hcbp_pkg::CODE_W-1:0] wr_data,
  input  logic                              rd_en,
  input  logic [hcbp_pkg::SYM_W-1:0]        rd_addr,
  output logic [LEN_W+hcbp_pkg::CODE_W-1:0] rd_data
);

  localparam int ENTRY_W = LEN_W + hcbp_pkg::CODE_W;

  logic [ENTRY_W-1:0] code_mem_r [hcbp_pkg::TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= code_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/hcbp_packer.sv -----
// ----------------------------------------------------------------------------
// hcbp_packer
// Lookup stage, left-aligned bit accumulator and output byte register.
// ----------------------------------------------------------------------------
`include "huffman_code_bit_packer_assert.svh"

module hcbp_packer #(
  parameter int LEN_W = 6
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hcbp_pkg::issue_t            issue,
  output logic                        issue_ready,
  input  logic [hcbp_pkg::CODE_W-1:0] rd_word,
  input  logic [LEN_W-1:0]            rd_len,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hcbp_pkg::out_item_t         out_data
);

  localparam int ACC_W  = hcbp_pkg::ACC_W;
  localparam int CNT_W  = hcbp_pkg::CNT_W;
  localparam int SH_W   = hcbp_pkg::SH_W;
  localparam int BYTE_W = hcbp_pkg::BYTE_W;
  localparam int CODE_W = hcbp_pkg::CODE_W;

  logic                      s1_valid_r, s1_valid_nxt;
  logic [hcbp_pkg::OP_W-1:0] s1_op_r, s1_op_nxt;
  logic [ACC_W-1:0]          acc_r, acc_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  hcbp_pkg::out_item_t       out_data_r, out_data_nxt;

  logic              slot_free;
  logic              emit;
  logic              flush_out;
  logic              s1_go;
  logic              has_room;
  logic [ACC_W-1:0]  acc_e;
  logic [CNT_W-1:0]  cnt_e;
  logic [CODE_W-1:0] word_m;
  logic [SH_W-1:0]   shamt;
  logic [ACC_W-1:0]  placed;

  always_comb begin
    slot_free = !out_valid_r || !out_stall;
    emit      = (cnt_r >= CNT_W'(BYTE_W)) && slot_free;
    acc_e     = emit ? {acc_r[ACC_W-BYTE_W-1:0], {BYTE_W{1'b0}}} : acc_r;
    cnt_e     = emit ? cnt_r - CNT_W'(BYTE_W) : cnt_r;
    has_room  = cnt_e < CNT_W'(BYTE_W);
    word_m    = rd_word & ~({CODE_W{1'b1}} << rd_len);
    shamt     = SH_W'(ACC_W) - SH_W'(cnt_e) - SH_W'(rd_len);
    placed    = {{(ACC_W-CODE_W){1'b0}}, word_m} << shamt;

    s1_go     = 1'b1;
    flush_out = 1'b0;
    acc_nxt   = acc_e;
    cnt_nxt   = cnt_e;

    if (s1_valid_r) begin
      priority if (s1_op_r == hcbp_pkg::OP_ENCODE) begin
        s1_go = has_room;
        if (has_room) begin
          acc_nxt = acc_e | placed;
          cnt_nxt = cnt_e + CNT_W'(rd_len);
        end
      end else if (s1_op_r == hcbp_pkg::OP_FLUSH) begin
        priority if (!has_room) begin
          s1_go = 1'b0;
        end else if (cnt_e == '0) begin
          acc_nxt = '0;
          cnt_nxt = '0;
        end else if (slot_free && !emit) begin
          flush_out = 1'b1;
          acc_nxt   = '0;
          cnt_nxt   = '0;
        end else begin
          s1_go = 1'b0;
        end
      end else begin
        s1_go = 1'b1;
      end
    end

    issue_ready  = !s1_valid_r || s1_go;
    s1_valid_nxt = issue_ready ? issue.valid : s1_valid_r;
    s1_op_nxt    = (issue_ready && issue.valid) ? issue.opcode : s1_op_r;

    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit || flush_out) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.packed_byte = acc_r[ACC_W-1 -: BYTE_W];
      out_data_nxt.last        = flush_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      acc_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r    <= s1_op_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `HCBP_ASSERT(a_cnt_range, cnt_r <= CNT_W'(ACC_W - 1), "bit count above accumulator size")
  `HCBP_ASSERT(a_acc_clean, (acc_r & ({ACC_W{1'b1}} >> cnt_r)) == '0, "stray bits below count")
  `HCBP_ASSERT(a_one_source, !(emit && flush_out), "byte and flush emitted together")
  `HCBP_ASSERT(a_flush_clears, (s1_valid_r && s1_go && s1_op_r == hcbp_pkg::OP_FLUSH) |=> cnt_r == '0, "flush left bits")
  `HCBP_ASSERT_RST(a_reset, !rst_n |=> (!out_valid_r && cnt_r == '0 && !s1_valid_r), "reset state")

endmodule

// ----- rtl/core/huffman_code_bit_packer.sv -----
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Static Huffman encoder back end: code table plus MSB-first bit packer.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries load, encode and flush
// items. A load writes the symbol's code word and length (capped to the
// code length limit) into the code table. An encode looks the symbol up and
// appends its code to the accumulator; each full byte leaves on the
// out_valid/out_stall/out_data channel, first bit in bit 7. A flush pads a
// partial byte with zeros and sends it with last set; nothing if empty.
// The first byte of an encode passes the table read, the accumulator merge
// and the output byte register before it is on out_data.
// Throughput: one item per cycle while the accumulator holds under eight
// bits and a flush of a partial byte finds the output slot free; bytes drain
// one per cycle unless stalled, so a code completing more than one byte holds
// the next item until all but its last byte have left, or all before a flush.
// Reset empties the accumulator and both pipeline stages; the table is not
// cleared, so every entry must be loaded before it is encoded.
// A stalled output holds its byte; the accumulator keeps packing until it
// holds a whole byte, then in_stall rises.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LENGTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hcbp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output hcbp_pkg::out_item_t out_data
);

  localparam int CAP   = (MAX_CODE_LENGTH < hcbp_pkg::CODE_W) ? MAX_CODE_LENGTH
                                                              : hcbp_pkg::CODE_W;
  localparam int LEN_W = $clog2(CAP + 1);

  logic                              in_accept;
  logic                              pk_ready;
  logic [LEN_W-1:0]                  ld_len;
  logic [LEN_W+hcbp_pkg::CODE_W-1:0] rd_data;
  hcbp_pkg::issue_t                  issue;

  assign in_stall  = !pk_ready;
  assign in_accept = in_valid && pk_ready;
  assign ld_len    = (in_data.code_length > hcbp_pkg::IN_LEN_W'(CAP))
                   ? LEN_W'(CAP) : in_data.code_length[LEN_W-1:0];

  always_comb begin
    issue.valid  = in_accept;
    issue.opcode = in_data.opcode;
  end

  hcbp_code_table #(
    .LEN_W (LEN_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (in_accept && in_data.opcode == hcbp_pkg::OP_LOAD),
    .wr_addr (in_data.symbol),
    .wr_data ({ld_len, in_data.code_bits}),
    .rd_en   (in_accept),
    .rd_addr (in_data.symbol),
    .rd_data (rd_data)
  );

  hcbp_packer #(
    .LEN_W (LEN_W)
  ) u_packer (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue       (issue),
    .issue_ready (pk_ready),
    .rd_word     (rd_data[hcbp_pkg::CODE_W-1:0]),
    .rd_len      (rd_data[LEN_W+hcbp_pkg::CODE_W-1:hcbp_pkg::CODE_W]),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ----- tb/huffman_code_bit_packer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_tb
// Self-checking bench for the Huffman code bit packer. A scoreboard keeps its
// own code table and bit accumulator and predicts every packed byte from each
// accepted load, encode and flush. Bytes are checked in order as they leave.
// Sender and receiver idle and stall at random, in phases.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_tb;

  localparam int MAX_LEN = 32;
  localparam int LEN_CAP = (MAX_LEN < hcbp_pkg::CODE_W) ? MAX_LEN : hcbp_pkg::CODE_W;
  localparam logic [hcbp_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 240;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 200000;

  class byte_scoreboard;
    logic [hcbp_pkg::CODE_W-1:0]   word_tbl [hcbp_pkg::TABLE_DEPTH];
    logic [hcbp_pkg::IN_LEN_W-1:0] len_tbl  [hcbp_pkg::TABLE_DEPTH];
    logic [6:0]                    pend_bits = '0;
    logic [2:0]                    pend_cnt = '0;
    hcbp_pkg::out_item_t           expected_q [$];
    int                            errors;
    int                            items_seen;
    int                            loads_seen;
    int                            bytes_checked;
    int                            lasts_checked;

    function void expect_byte(hcbp_pkg::out_item_t item);
      expected_q = {expected_q, item};
    endfunction

    function void note_input(hcbp_pkg::in_item_t it);
      logic [63:0]         acc;
      logic [63:0]         word;
      int                  len;
      int                  total;
      hcbp_pkg::out_item_t exp_item;
      items_seen++;
      unique case (it.opcode)
        hcbp_pkg::OP_LOAD: begin
          len = it.code_length;
          if (len > LEN_CAP) len = LEN_CAP;
          word_tbl[it.symbol] = it.code_bits;
          len_tbl[it.symbol]  = hcbp_pkg::IN_LEN_W'(len);
          loads_seen++;
        end
        hcbp_pkg::OP_ENCODE: begin
          len   = len_tbl[it.symbol];
          word  = {32'd0, word_tbl[it.symbol]} & ((64'd1 << len) - 64'd1);
          acc   = ({57'd0, pend_bits} << len) | word;
          total = int'(pend_cnt) + len;
          while (total >= hcbp_pkg::BYTE_W) begin
            exp_item.packed_byte = 8'(acc >> (total - hcbp_pkg::BYTE_W));
            exp_item.last        = 1'b0;
            expect_byte(exp_item);
            total -= hcbp_pkg::BYTE_W;
          end
          pend_bits = 7'(acc & ((64'd1 << total) - 64'd1));
          pend_cnt  = 3'(total);
        end
        hcbp_pkg::OP_FLUSH: begin
          if (pend_cnt != 3'd0) begin
            exp_item.packed_byte =
              8'(16'(pend_bits) << (hcbp_pkg::BYTE_W - int'(pend_cnt)));
            exp_item.last        = 1'b1;
            expect_byte(exp_item);
          end
          pend_bits = '0;
          pend_cnt  = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(hcbp_pkg::out_item_t got);
      hcbp_pkg::out_item_t exp_item;
      if (expected_q.size() == 0) begin
        $error("unexpected byte %02h (last %0b) with nothing pending",
               got.packed_byte, got.last);
        errors++;
        return;
      end
      exp_item = expected_q.pop_front();
      bytes_checked++;
      if (got.last) lasts_checked++;
      if (got.packed_byte !== exp_item.packed_byte) begin
        $error("packed_byte: expected %02h, got %02h", exp_item.packed_byte,
               got.packed_byte);
        errors++;
      end
      if (got.last !== exp_item.last) begin
        $error("last: expected %0b, got %0b", exp_item.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  hcbp_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  hcbp_pkg::out_item_t out_data;

  byte_scoreboard sb = new();
  bit        in_gaps_on = 1'b1;
  bit        out_gaps_on = 1'b1;
  bit        loaded [hcbp_pkg::TABLE_DEPTH];
  logic [hcbp_pkg::SYM_W-1:0] loaded_q [$];
  int        cycle_count = 0;

  huffman_code_bit_packer #(.MAX_CODE_LENGTH(MAX_LEN)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
               sb.expected_q.size());
      $display("huffman_code_bit_packer_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // receiver: random stall before each transfer
  initial begin
    int unsigned n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = out_gaps_on ? $urandom_range(0, 19) : 0;
      if (n != 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input hcbp_pkg::in_item_t it);
    int unsigned gap;
    gap = in_gaps_on ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    if (it.opcode == hcbp_pkg::OP_LOAD && !loaded[it.symbol]) begin
      loaded[it.symbol] = 1'b1;
      loaded_q = {loaded_q, it.symbol};
    end
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_op(input logic [hcbp_pkg::OP_W-1:0] op,
                         input logic [hcbp_pkg::SYM_W-1:0] sym,
                         input logic [hcbp_pkg::CODE_W-1:0] code,
                         input logic [hcbp_pkg::IN_LEN_W-1:0] len);
    hcbp_pkg::in_item_t it;
    it.opcode      = op;
    it.symbol      = sym;
    it.code_bits   = code;
    it.code_length = len;
    send_item(it);
  endtask

  // sender holds off until every predicted byte has left
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    hcbp_pkg::in_item_t it;
    int unsigned        r;
    int                 counted;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, overlong and zero lengths, masking, empty flush
    send_op(hcbp_pkg::OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
    send_op(hcbp_pkg::OP_LOAD, 8'hFF, 32'h0000_0000, 6'd1);
    send_op(hcbp_pkg::OP_LOAD, 8'h55, 32'hAAAA_AAAA, 6'd63);
    send_op(hcbp_pkg::OP_LOAD, 8'h0F, 32'h1234_5678, 6'd0);
    send_op(hcbp_pkg::OP_LOAD, 8'hA5, 32'hFFFF_FFFF, 6'd3);
    send_op(hcbp_pkg::OP_LOAD, 8'h3C, 32'hFFFF_FFE5, 6'd33);
    send_op(hcbp_pkg::OP_FLUSH, 8'hC3, 32'hDEAD_BEEF, 6'd17);
    send_op(hcbp_pkg::OP_ENCODE, 8'h00, 32'h5A5A_5A5A, 6'd63);
    send_op(hcbp_pkg::OP_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'd0);
    send_op(hcbp_pkg::OP_ENCODE, 8'h0F, 32'h0, 6'd5);
    send_op(hcbp_pkg::OP_ENCODE, 8'hA5, 32'h0, 6'd0);
    send_op(hcbp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0);
    send_op(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_op(hcbp_pkg::OP_ENCODE, 8'h55, 32'h0, 6'd0);
    send_op(hcbp_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_op(hcbp_pkg::OP_ENCODE, 8'h55, 32'h0, 6'd0);
    send_op(hcbp_pkg::OP_ENCODE, 8'h3C, 32'h0, 6'd0);
    send_op(OP_UNUSED, 8'h00, 32'h0, 6'd0);
    send_op(hcbp_pkg::OP_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_op(hcbp_pkg::OP_FLUSH, 8'h12, 32'h0, 6'd1);
    send_op(hcbp_pkg::OP_LOAD, 8'hFF, 32'h0000_0001, 6'd1);
    send_op(hcbp_pkg::OP_ENCODE, 8'hFF, 32'h0, 6'd0);
    send_op(hcbp_pkg::OP_FLUSH, 8'h00, 32'h0, 6'd0);
    wait_drained();

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 45 == 0) begin
        r = $urandom_range(0, 3);
        in_gaps_on  = r[0];
        out_gaps_on = r[1];
      end
      if (counted == RANDOM_ITEMS / 2) wait_drained();
      it.symbol      = hcbp_pkg::SYM_W'($urandom);
      it.code_bits   = $urandom;
      it.code_length = hcbp_pkg::IN_LEN_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 12 || loaded_q.size() == 0) begin
        it.opcode = hcbp_pkg::OP_LOAD;
        r = $urandom_range(0, 99);
        if (r < 60)      it.code_length = hcbp_pkg::IN_LEN_W'($urandom_range(1, 8));
        else if (r < 85) it.code_length = hcbp_pkg::IN_LEN_W'($urandom_range(9, 24));
        else if (r < 93) it.code_length = hcbp_pkg::IN_LEN_W'($urandom_range(25, 32));
        else if (r < 97) it.code_length = hcbp_pkg::IN_LEN_W'($urandom_range(33, 63));
        else             it.code_length = '0;
      end else if (r < 84) begin
        it.opcode = hcbp_pkg::OP_ENCODE;
        it.symbol = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
      end else if (r < 95) begin
        it.opcode = hcbp_pkg::OP_FLUSH;
      end else begin
        it.opcode = OP_UNUSED;
      end
      send_item(it);
      if (it.opcode != OP_UNUSED) counted++;
    end

    wait_drained();
    $display("%0d items accepted (%0d table loads), %0d bytes checked, %0d flush bytes",
             sb.items_seen, sb.loads_seen, sb.bytes_checked, sb.lasts_checked);
    $display("%0d distinct symbols loaded, %0d cycles", loaded_q.size(), cycle_count);
    if (sb.errors == 0) begin
      $display("huffman_code_bit_packer_tb: done, clean");
    end else begin
      $display("huffman_code_bit_packer_tb: done, errors");
    end
    $finish;
  end

endmodule
